// File: rtl/core/pcsc_pkg.sv
// Shared types, constants and fixed-point helpers for the pixel color space converter.
// Depends on nothing; every other file of the converter imports it.
package pcsc_pkg;

    // Conversion modes held in the mode register.
    typedef enum logic [2:0] {
        MODE_RGB2YUV = 3'd0,
        MODE_YUV2RGB = 3'd1,
        MODE_GRAY    = 3'd2,
        MODE_THRESH  = 3'd3,
        MODE_BOOST   = 3'd4
    } t_mode;

    localparam int COMP_W     = 8;
    localparam int MODE_W     = 3;
    localparam int RES_W      = 11;
    localparam int OFS_W      = 10;
    localparam int Y_OFS      = 16;
    localparam int C_OFS      = 128;
    localparam int Y_CLIP     = 235;
    localparam int BIN_HI     = 255;
    localparam int GRAY_MUL   = 256;
    localparam int GRAY_DIV   = 220;
    localparam int GRAY_RECIP = 19066;
    localparam int GRAY_SHIFT = 14;
    localparam int MILLI      = 1000;

    // Pixel as it enters the pipeline, with the mode latched alongside it.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [COMP_W-1:0] c0;
        logic [COMP_W-1:0] c1;
        logic [COMP_W-1:0] c2;
    } t_ctl;

    // Side results that ride along to the output stage.
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic                    bin;
        logic [COMP_W-1:0]       gray;
        logic signed [RES_W-1:0] y;
        logic signed [RES_W-1:0] u;
        logic signed [RES_W-1:0] v;
    } t_tag;

    // Coefficient k/1000 rounded to f fraction bits, ties away from zero.
    function automatic longint coef_milli(input int k, input int f);
        return ((longint'(k) <<< f) + longint'(MILLI / 2)) / MILLI;
    endfunction

    // The luma gain 1.1 rounded to f fraction bits.
    function automatic longint coef_boost(input int f);
        return ((longint'(11) <<< f) + longint'(5)) / 10;
    endfunction

    // Divide by 2^f, truncating toward zero.
    function automatic longint trunc_frac(input longint s, input int f);
        longint bias;
        bias = (longint'(1) <<< f) - longint'(1);
        return (s < 0) ? ((s + bias) >>> f) : (s >>> f);
    endfunction

    // Gray level (Y-16)*256/220 for a non-negative offset luma. The scale 256/220 is
    // applied as a multiply by its reciprocal and a shift, which is exact for every
    // 8-bit offset.
    function automatic logic [COMP_W-1:0] gray_of(input logic [COMP_W-1:0] yo);
        int prod;
        prod = int'(yo) * GRAY_RECIP;
        return COMP_W'(prod >>> GRAY_SHIFT);
    endfunction

endpackage

// File: rtl/core/pcsc_if.sv
// Valid/ready channel interfaces for the pixel color space converter.
// Depends on pcsc_pkg for the field widths.
interface pcsc_pix_if
    import pcsc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] first_component;
    logic [COMP_W-1:0] second_component;
    logic [COMP_W-1:0] third_component;

    modport source (output valid, first_component, second_component, third_component,
                    input ready);
    modport sink   (input valid, first_component, second_component, third_component,
                    output ready);
endinterface

interface pcsc_res_if
    import pcsc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] first_result;
    logic signed [RES_W-1:0] second_result;
    logic signed [RES_W-1:0] third_result;

    modport source (output valid, first_result, second_result, third_result,
                    input ready);
    modport sink   (input valid, first_result, second_result, third_result,
                    output ready);
endinterface

interface pcsc_cfg_if
    import pcsc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] conversion_mode;

    modport source (output valid, conversion_mode, input ready);
    modport sink   (input valid, conversion_mode, output ready);
endinterface

// File: rtl/core/pcsc_fwd.sv
// RGB to YUV section: coefficient products in one stage, offset sums in the next.
// Depends on pcsc_pkg.
module pcsc_fwd
    import pcsc_pkg::*;
#(
    parameter int P_FRAC = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    output logic                    o_rdy,
    input  t_ctl                    i_ctl,
    output logic                    o_vld,
    input  logic                    i_rdy,
    output t_ctl                    o_ctl,
    output logic signed [RES_W-1:0] o_y,
    output logic signed [RES_W-1:0] o_u,
    output logic signed [RES_W-1:0] o_v
);
    localparam int PW = P_FRAC + 12;

    localparam logic signed [PW-1:0] K_YR = PW'(coef_milli(257, P_FRAC));
    localparam logic signed [PW-1:0] K_YG = PW'(coef_milli(504, P_FRAC));
    localparam logic signed [PW-1:0] K_YB = PW'(coef_milli(98, P_FRAC));
    localparam logic signed [PW-1:0] K_UR = -PW'(coef_milli(148, P_FRAC));
    localparam logic signed [PW-1:0] K_UG = -PW'(coef_milli(291, P_FRAC));
    localparam logic signed [PW-1:0] K_UB = PW'(coef_milli(439, P_FRAC));
    localparam logic signed [PW-1:0] K_VR = PW'(coef_milli(439, P_FRAC));
    localparam logic signed [PW-1:0] K_VG = -PW'(coef_milli(368, P_FRAC));
    localparam logic signed [PW-1:0] K_VB = -PW'(coef_milli(71, P_FRAC));
    localparam longint OFS_Y = longint'(Y_OFS) <<< P_FRAC;
    localparam longint OFS_C = longint'(C_OFS) <<< P_FRAC;

    logic                    r_a_vld;
    t_ctl                    r_a_ctl;
    logic signed [PW-1:0]    r_a_p [9];
    logic signed [PW-1:0]    n_a_p [9];
    logic                    r_b_vld;
    t_ctl                    r_b_ctl;
    logic signed [RES_W-1:0] r_b_y, r_b_u, r_b_v;
    logic signed [RES_W-1:0] n_b_y, n_b_u, n_b_v;
    logic signed [COMP_W+1:0] s_r, s_g, s_b;
    logic                    a_adv, b_adv;

    // A stage moves when it is empty or its successor moves.
    assign b_adv = !r_b_vld || i_rdy;
    assign a_adv = !r_a_vld || b_adv;
    assign o_rdy = a_adv;

    // Nine coefficient products of the three components.
    always_comb begin
        s_r = $signed({2'b00, i_ctl.c0});
        s_g = $signed({2'b00, i_ctl.c1});
        s_b = $signed({2'b00, i_ctl.c2});
        n_a_p[0] = K_YR * s_r;
        n_a_p[1] = K_YG * s_g;
        n_a_p[2] = K_YB * s_b;
        n_a_p[3] = K_UR * s_r;
        n_a_p[4] = K_UG * s_g;
        n_a_p[5] = K_UB * s_b;
        n_a_p[6] = K_VR * s_r;
        n_a_p[7] = K_VG * s_g;
        n_a_p[8] = K_VB * s_b;
    end

    // Row sums with offsets, truncated toward zero.
    always_comb begin
        n_b_y = RES_W'(trunc_frac(longint'(r_a_p[0]) + longint'(r_a_p[1])
                                  + longint'(r_a_p[2]) + OFS_Y, P_FRAC));
        n_b_u = RES_W'(trunc_frac(longint'(r_a_p[3]) + longint'(r_a_p[4])
                                  + longint'(r_a_p[5]) + OFS_C, P_FRAC));
        n_b_v = RES_W'(trunc_frac(longint'(r_a_p[6]) + longint'(r_a_p[7])
                                  + longint'(r_a_p[8]) + OFS_C, P_FRAC));
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (a_adv) r_a_vld <= i_vld;
            if (b_adv) r_b_vld <= r_a_vld;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_a_ctl <= i_ctl;
            r_a_p   <= n_a_p;
        end
        if (b_adv) begin
            r_b_ctl <= r_a_ctl;
            r_b_y   <= n_b_y;
            r_b_u   <= n_b_u;
            r_b_v   <= n_b_v;
        end
    end

    assign o_vld = r_b_vld;
    assign o_ctl = r_b_ctl;
    assign o_y   = r_b_y;
    assign o_u   = r_b_u;
    assign o_v   = r_b_v;
endmodule

// File: rtl/core/pcsc_mid.sv
// Middle section: source selection, gray level, threshold and luma boost, then offset removal.
// Depends on pcsc_pkg.
module pcsc_mid
    import pcsc_pkg::*;
#(
    parameter int P_FRAC = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    output logic                    o_rdy,
    input  t_ctl                    i_ctl,
    input  logic signed [RES_W-1:0] i_y,
    input  logic signed [RES_W-1:0] i_u,
    input  logic signed [RES_W-1:0] i_v,
    output logic                    o_vld,
    input  logic                    i_rdy,
    output t_tag                    o_tag,
    output logic signed [OFS_W-1:0] o_yo,
    output logic signed [OFS_W-1:0] o_uo,
    output logic signed [OFS_W-1:0] o_vo
);
    localparam int PW = P_FRAC + 12;
    localparam logic signed [PW-1:0] K_BOOST = PW'(coef_boost(P_FRAC));

    logic                    r_c_vld;
    t_tag                    r_c_tag;
    logic signed [RES_W-1:0] r_c_y, r_c_u, r_c_v;
    logic signed [PW-1:0]    r_c_bp;
    t_tag                    n_c_tag;
    logic signed [RES_W-1:0] n_c_y, n_c_u, n_c_v;
    logic signed [PW-1:0]    n_c_bp;
    logic                    r_d_vld;
    t_tag                    r_d_tag;
    logic signed [OFS_W-1:0] r_d_yo, r_d_uo, r_d_vo;
    logic signed [OFS_W-1:0] n_d_yo, n_d_uo, n_d_vo;
    logic signed [RES_W-1:0] y_b;
    logic signed [RES_W-1:0] y_bst;
    logic signed [RES_W-1:0] y_ofs;
    logic                    c_adv, d_adv;

    assign d_adv = !r_d_vld || i_rdy;
    assign c_adv = !r_c_vld || d_adv;
    assign o_rdy = c_adv;

    // Pick the YUV source, form the gray level, the threshold bit and the boost product.
    always_comb begin
        y_ofs          = i_y - RES_W'(Y_OFS);
        n_c_tag.mode   = i_ctl.mode;
        n_c_tag.bin    = i_ctl.c0[COMP_W-1];
        n_c_tag.gray   = gray_of(y_ofs[COMP_W-1:0]);
        n_c_tag.y      = i_y;
        n_c_tag.u      = i_u;
        n_c_tag.v      = i_v;
        n_c_bp         = K_BOOST * $signed({1'b0, i_y});
        if (i_ctl.mode == MODE_YUV2RGB) begin
            n_c_y = $signed({3'b000, i_ctl.c0});
            n_c_u = $signed({3'b000, i_ctl.c1});
            n_c_v = $signed({3'b000, i_ctl.c2});
        end else begin
            n_c_y = i_y;
            n_c_u = i_u;
            n_c_v = i_v;
        end
    end

    // Boosted luma with clip, then the offsets of the inverse transform.
    always_comb begin
        y_bst = RES_W'(trunc_frac(longint'(r_c_bp), P_FRAC));
        if (r_c_tag.mode == MODE_BOOST) begin
            y_b = (y_bst > RES_W'(Y_CLIP)) ? RES_W'(Y_CLIP) : y_bst;
        end else begin
            y_b = r_c_y;
        end
        n_d_yo = OFS_W'(y_b - RES_W'(Y_OFS));
        n_d_uo = OFS_W'(r_c_u - RES_W'(C_OFS));
        n_d_vo = OFS_W'(r_c_v - RES_W'(C_OFS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (c_adv) r_c_vld <= i_vld;
            if (d_adv) r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_c_tag <= n_c_tag;
            r_c_y   <= n_c_y;
            r_c_u   <= n_c_u;
            r_c_v   <= n_c_v;
            r_c_bp  <= n_c_bp;
        end
        if (d_adv) begin
            r_d_tag <= r_c_tag;
            r_d_yo  <= n_d_yo;
            r_d_uo  <= n_d_uo;
            r_d_vo  <= n_d_vo;
        end
    end

    assign o_vld = r_d_vld;
    assign o_tag = r_d_tag;
    assign o_yo  = r_d_yo;
    assign o_uo  = r_d_uo;
    assign o_vo  = r_d_vo;
endmodule

// File: rtl/core/pcsc_inv.sv
// YUV to RGB section: coefficient products in one stage, sums in the next.
// Depends on pcsc_pkg.
module pcsc_inv
    import pcsc_pkg::*;
#(
    parameter int P_FRAC = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    output logic                    o_rdy,
    input  t_tag                    i_tag,
    input  logic signed [OFS_W-1:0] i_yo,
    input  logic signed [OFS_W-1:0] i_uo,
    input  logic signed [OFS_W-1:0] i_vo,
    output logic                    o_vld,
    input  logic                    i_rdy,
    output t_tag                    o_tag,
    output logic signed [RES_W-1:0] o_r,
    output logic signed [RES_W-1:0] o_g,
    output logic signed [RES_W-1:0] o_b
);
    localparam int PW = P_FRAC + 12;

    localparam logic signed [PW-1:0] K_Y  = PW'(coef_milli(1164, P_FRAC));
    localparam logic signed [PW-1:0] K_RV = PW'(coef_milli(1596, P_FRAC));
    localparam logic signed [PW-1:0] K_GU = PW'(coef_milli(392, P_FRAC));
    localparam logic signed [PW-1:0] K_GV = PW'(coef_milli(813, P_FRAC));
    localparam logic signed [PW-1:0] K_BU = PW'(coef_milli(2017, P_FRAC));

    logic                    r_e_vld;
    t_tag                    r_e_tag;
    logic signed [PW-1:0]    r_e_p [5];
    logic signed [PW-1:0]    n_e_p [5];
    logic                    r_f_vld;
    t_tag                    r_f_tag;
    logic signed [RES_W-1:0] r_f_r, r_f_g, r_f_b;
    logic signed [RES_W-1:0] n_f_r, n_f_g, n_f_b;
    logic                    e_adv, f_adv;

    assign f_adv = !r_f_vld || i_rdy;
    assign e_adv = !r_e_vld || f_adv;
    assign o_rdy = e_adv;

    // Five distinct coefficient products.
    always_comb begin
        n_e_p[0] = K_Y  * i_yo;
        n_e_p[1] = K_RV * i_vo;
        n_e_p[2] = K_GU * i_uo;
        n_e_p[3] = K_GV * i_vo;
        n_e_p[4] = K_BU * i_uo;
    end

    // Channel sums, truncated toward zero.
    always_comb begin
        n_f_r = RES_W'(trunc_frac(longint'(r_e_p[0]) + longint'(r_e_p[1]), P_FRAC));
        n_f_g = RES_W'(trunc_frac(longint'(r_e_p[0]) - longint'(r_e_p[2])
                                  - longint'(r_e_p[3]), P_FRAC));
        n_f_b = RES_W'(trunc_frac(longint'(r_e_p[0]) + longint'(r_e_p[4]), P_FRAC));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else begin
            if (e_adv) r_e_vld <= i_vld;
            if (f_adv) r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_adv) begin
            r_e_tag <= i_tag;
            r_e_p   <= n_e_p;
        end
        if (f_adv) begin
            r_f_tag <= r_e_tag;
            r_f_r   <= n_f_r;
            r_f_g   <= n_f_g;
            r_f_b   <= n_f_b;
        end
    end

    assign o_vld = r_f_vld;
    assign o_tag = r_f_tag;
    assign o_r   = r_f_r;
    assign o_g   = r_f_g;
    assign o_b   = r_f_b;
endmodule

// File: rtl/core/pixel_color_space_converter.sv
// Top level of the pixel color space converter: mode register, three pipeline sections
// and the output register. Depends on pcsc_pkg, pcsc_if, pcsc_fwd, pcsc_mid and pcsc_inv.

// Converts one pixel per clock, while the output is not stalled, between RGB and BT.601
// studio-range YUV, or to gray, a binary threshold, or a luma-boosted RGB, as the mode
// register selects. Every pixel goes through the same seven register stages (two for the
// forward products and sums, two for source selection and boost, two for the inverse products
// and sums, one output register). Each stage holds its pixel while the stage after it is full
// and stalled, so a stall at the output only blocks the input once every stage is occupied. The
// mode is latched with each pixel; write it while no pixels are in flight. The configuration
// channel is always ready.
module pixel_color_space_converter
    import pcsc_pkg::*;
#(
    parameter int COEFF_FRACTION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcsc_pix_if.sink   i_pix,
    pcsc_cfg_if.sink   i_cfg,
    pcsc_res_if.source o_res
);
    logic [MODE_W-1:0]       r_mode;
    t_ctl                    in_ctl;

    logic                    fwd_rdy, fwd_vld;
    t_ctl                    fwd_ctl;
    logic signed [RES_W-1:0] fwd_y, fwd_u, fwd_v;

    logic                    mid_rdy, mid_vld;
    t_tag                    mid_tag;
    logic signed [OFS_W-1:0] mid_yo, mid_uo, mid_vo;

    logic                    inv_rdy, inv_vld;
    t_tag                    inv_tag;
    logic signed [RES_W-1:0] inv_r, inv_g, inv_b;

    logic                    r_o_vld;
    logic [MODE_W-1:0]       r_o_mode;
    logic signed [RES_W-1:0] r_o_first, r_o_second, r_o_third;
    logic signed [RES_W-1:0] n_o_first, n_o_second, n_o_third;
    logic                    o_adv;

    // Mode register.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RGB2YUV;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_mode <= i_cfg.conversion_mode;
        end
    end

    // Input pixel with the current mode attached.
    always_comb begin
        in_ctl.mode = r_mode;
        in_ctl.c0   = i_pix.first_component;
        in_ctl.c1   = i_pix.second_component;
        in_ctl.c2   = i_pix.third_component;
    end

    assign i_pix.ready = fwd_rdy;

    pcsc_fwd #(.P_FRAC(COEFF_FRACTION_BITS)) u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_pix.valid),
        .o_rdy   (fwd_rdy),
        .i_ctl   (in_ctl),
        .o_vld   (fwd_vld),
        .i_rdy   (mid_rdy),
        .o_ctl   (fwd_ctl),
        .o_y     (fwd_y),
        .o_u     (fwd_u),
        .o_v     (fwd_v)
    );

    pcsc_mid #(.P_FRAC(COEFF_FRACTION_BITS)) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (fwd_vld),
        .o_rdy   (mid_rdy),
        .i_ctl   (fwd_ctl),
        .i_y     (fwd_y),
        .i_u     (fwd_u),
        .i_v     (fwd_v),
        .o_vld   (mid_vld),
        .i_rdy   (inv_rdy),
        .o_tag   (mid_tag),
        .o_yo    (mid_yo),
        .o_uo    (mid_uo),
        .o_vo    (mid_vo)
    );

    pcsc_inv #(.P_FRAC(COEFF_FRACTION_BITS)) u_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (mid_vld),
        .o_rdy   (inv_rdy),
        .i_tag   (mid_tag),
        .i_yo    (mid_yo),
        .i_uo    (mid_uo),
        .i_vo    (mid_vo),
        .o_vld   (inv_vld),
        .i_rdy   (o_adv),
        .o_tag   (inv_tag),
        .o_r     (inv_r),
        .o_g     (inv_g),
        .o_b     (inv_b)
    );

    // Result selection by mode; unused fields and unused modes give zero.
    always_comb begin
        n_o_first  = '0;
        n_o_second = '0;
        n_o_third  = '0;
        case (t_mode'(inv_tag.mode))
            MODE_RGB2YUV: begin
                n_o_first  = inv_tag.y;
                n_o_second = inv_tag.u;
                n_o_third  = inv_tag.v;
            end
            MODE_YUV2RGB, MODE_BOOST: begin
                n_o_first  = inv_r;
                n_o_second = inv_g;
                n_o_third  = inv_b;
            end
            MODE_GRAY: begin
                n_o_first = $signed({3'b000, inv_tag.gray});
            end
            MODE_THRESH: begin
                n_o_first = inv_tag.bin ? RES_W'(BIN_HI) : '0;
            end
            default: begin
                n_o_first = '0;
            end
        endcase
    end

    // Output register.
    assign o_adv = !r_o_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_adv) begin
            r_o_vld <= inv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_o_mode   <= inv_tag.mode;
            r_o_first  <= n_o_first;
            r_o_second <= n_o_second;
            r_o_third  <= n_o_third;
        end
    end

    assign o_res.valid         = r_o_vld;
    assign o_res.first_result  = r_o_first;
    assign o_res.second_result = r_o_second;
    assign o_res.third_result  = r_o_third;

    // Gray and threshold results carry nothing in the second and third fields.
    a_mono_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && (r_o_mode == MODE_GRAY || r_o_mode == MODE_THRESH))
        |-> (r_o_second == '0 && r_o_third == '0))
        else $error("Second or third result nonzero in a single-channel mode.");

    // A threshold result is black or white only.
    a_thresh_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_mode == MODE_THRESH)
        |-> (r_o_first == '0 || r_o_first == RES_W'(BIN_HI)))
        else $error("Threshold result is neither 0 nor 255.");

    // Forward luma always stays within the studio range.
    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_mode == MODE_RGB2YUV)
        |-> (r_o_first >= RES_W'(Y_OFS) && r_o_first <= RES_W'(Y_CLIP)))
        else $error("Luma result outside the studio range.");
endmodule
